// ===== hw/rtl/rds_pkg.sv =====
// ----------------------------------------------------------------------------
// rds_pkg
// Shared constants, types and register codes for the reaction-diffusion
// stencil step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rds_pkg;

  // grid geometry
  localparam int GRID_ROWS = 256;
  localparam int GRID_COLS = 256;
  // cell history: two rows plus two cells
  localparam int HIST_LEN  = 2 * GRID_COLS + 2;

  localparam int VAL_W  = 18;
  localparam int COEF_W = 16;
  localparam int SLOT_W = $clog2(HIST_LEN);
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int PEND_W = $clog2(GRID_COLS + 3);

  localparam int VAL_MAX = 131071;
  localparam int VAL_MIN = -131072;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // register indexes
  localparam logic [2:0] REG_DIFF_U    = 3'd0;
  localparam logic [2:0] REG_DIFF_V    = 3'd1;
  localparam logic [2:0] REG_FEED      = 3'd2;
  localparam logic [2:0] REG_KILL      = 3'd3;
  localparam logic [2:0] REG_TIME_STEP = 3'd4;
  localparam logic [2:0] REG_V_THRESH  = 3'd5;

  // register reset values
  localparam logic [COEF_W-1:0] DIFF_U_RST    = 16'd9175;
  localparam logic [COEF_W-1:0] DIFF_V_RST    = 16'd4588;
  localparam logic [COEF_W-1:0] FEED_RST      = 16'd1966;
  localparam logic [COEF_W-1:0] KILL_RST      = 16'd4247;
  localparam logic [COEF_W-1:0] TIME_STEP_RST = 16'd3932;
  localparam logic [VAL_W-1:0]  V_THRESH_RST  = 18'd6554;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_C,
    S_RD_U,
    S_RD_D,
    S_RD_L,
    S_RD_R,
    S_ACC,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_MUL3,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rds_if.sv =====
// ----------------------------------------------------------------------------
// rds_in_if / rds_out_if
// Valid/ready stream interfaces for input cells and result cells.
// ----------------------------------------------------------------------------
`default_nettype none

interface rds_in_if;
  import rds_pkg::*;
  logic valid;
  logic ready;
  logic drain;
  val_t u_in;
  val_t v_in;
  modport source (output valid, drain, u_in, v_in, input ready);
  modport sink   (input valid, drain, u_in, v_in, output ready);
endinterface

interface rds_out_if;
  import rds_pkg::*;
  logic valid;
  logic ready;
  val_t u_out;
  val_t v_out;
  logic above_threshold;
  logic frame_last;
  modport source (output valid, u_out, v_out, above_threshold, frame_last, input ready);
  modport sink   (input valid, u_out, v_out, above_threshold, frame_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rds_ram.sv =====
// ----------------------------------------------------------------------------
// rds_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/reaction_diffusion_stencil_step_unit.sv =====
// ----------------------------------------------------------------------------
// reaction_diffusion_stencil_step_unit
// One explicit-Euler Gray-Scott step over a streamed grid, 5-point stencil.
// ----------------------------------------------------------------------------
// Usage:
//  in_chan  : cells (drain, u_in, v_in) in raster order, column fastest.
//             A drain word carries no cell; at a frame boundary it pushes
//             out the oldest pending cell of the previous frame.
//  out_chan : updated (u_out, v_out), above_threshold, frame_last.
//  APB port : coefficient and threshold registers, written while idle.
// Results lag the input by one row plus one cell. For a word that yields
// a result, the history reads go through the single read port of the row
// memories one per cycle: centre, up and down for a border cell, which is
// passed through unchanged, and also left and right for an interior cell,
// which then goes through the registered steps ACC, MUL1, MUL2, SUM, MUL3.
// The result sits in an output register; the next word is accepted while
// it waits, and a new result waits in the final step until it is taken.
// Reset clears counters, state, configuration registers and output valid;
// the row memories are not cleared (no unwritten cell reaches a result).
`default_nettype none

module reaction_diffusion_stencil_step_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  rds_in_if.sink                          in_chan,
  rds_out_if.source                       out_chan,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rds_pkg::CFG_AW-1:0] paddr,
  input  wire logic [rds_pkg::CFG_DW-1:0] pwdata,
  output logic      [rds_pkg::CFG_DW-1:0] prdata,
  output logic                            pready
);
  import rds_pkg::*;

  localparam int SW1 = SLOT_W + 1;

  // wrap a slot sum that is below twice the history length
  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SW1-1:0] s);
    if (s >= SW1'(HIST_LEN)) begin
      return SLOT_W'(s - SW1'(HIST_LEN));
    end
    return s[SLOT_W-1:0];
  endfunction

  // configuration registers
  logic [COEF_W-1:0] du_r, dv_r, feed_r, kill_r, dt_r;
  val_t              thr_r;
  logic              cfg_we;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      du_r   <= DIFF_U_RST;
      dv_r   <= DIFF_V_RST;
      feed_r <= FEED_RST;
      kill_r <= KILL_RST;
      dt_r   <= TIME_STEP_RST;
      thr_r  <= V_THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DIFF_U:    du_r   <= pwdata[COEF_W-1:0];
        REG_DIFF_V:    dv_r   <= pwdata[COEF_W-1:0];
        REG_FEED:      feed_r <= pwdata[COEF_W-1:0];
        REG_KILL:      kill_r <= pwdata[COEF_W-1:0];
        REG_TIME_STEP: dt_r   <= pwdata[COEF_W-1:0];
        REG_V_THRESH:  thr_r  <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (cfg_idx)
      REG_DIFF_U:    prdata = CFG_DW'(du_r);
      REG_DIFF_V:    prdata = CFG_DW'(dv_r);
      REG_FEED:      prdata = CFG_DW'(feed_r);
      REG_KILL:      prdata = CFG_DW'(kill_r);
      REG_TIME_STEP: prdata = CFG_DW'(dt_r);
      REG_V_THRESH:  prdata = CFG_DW'(thr_r);
      default:       prdata = '0;
    endcase
  end

  // control state
  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] ws_r, c_r;
  logic [PEND_W-1:0] pend_r;
  logic [ROW_W-1:0]  in_row_r, out_row_r;
  logic [COL_W-1:0]  in_col_r, out_col_r;
  logic              border_r;

  logic              acc_in, is_cell, emit_now, out_load;
  logic [SLOT_W-1:0] centre_slot, up_slot, dn_slot, lf_slot, rt_slot, raddr;

  assign acc_in  = in_chan.valid & in_chan.ready;
  assign is_cell = ~in_chan.drain;

  // oldest pending cell and its neighbours in the history ring
  assign centre_slot = slot_wrap(SW1'(ws_r) + SW1'(HIST_LEN) - SW1'(pend_r));
  assign up_slot     = slot_wrap(SW1'(c_r) + SW1'(HIST_LEN - GRID_COLS));
  assign dn_slot     = slot_wrap(SW1'(c_r) + SW1'(GRID_COLS));
  assign lf_slot     = slot_wrap(SW1'(c_r) + SW1'(HIST_LEN - 1));
  assign rt_slot     = slot_wrap(SW1'(c_r) + SW1'(1));

  // a cell word emits once the window is full; a drain word only at the
  // frame boundary with cells still pending
  always_comb begin
    if (is_cell) begin
      emit_now = (pend_r >= PEND_W'(GRID_COLS + 1));
    end else begin
      emit_now = (in_row_r == '0) && (in_col_r == '0) && (pend_r != '0);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (acc_in && emit_now) state_nxt = S_RD_C;
      S_RD_C: state_nxt = S_RD_U;
      S_RD_U: state_nxt = S_RD_D;
      S_RD_D: state_nxt = border_r ? S_FIN : S_RD_L;
      S_RD_L: state_nxt = S_RD_R;
      S_RD_R: state_nxt = S_ACC;
      S_ACC:  state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_FIN;
      S_FIN:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs: input ready, read address, result load
  always_comb begin
    in_chan.ready = 1'b0;
    raddr         = c_r;
    out_load      = 1'b0;
    case (state_r)
      S_IDLE: in_chan.ready = 1'b1;
      S_RD_C: raddr = c_r;
      S_RD_U: raddr = up_slot;
      S_RD_D: raddr = dn_slot;
      S_RD_L: raddr = lf_slot;
      S_RD_R: raddr = rt_slot;
      S_FIN:  out_load = ~out_chan.valid | out_chan.ready;
      default: ;
    endcase
  end

  // row memories
  logic [VAL_W-1:0] u_rd, v_rd;
  logic             ram_we;
  assign ram_we = acc_in & is_cell;

  rds_ram #(.WIDTH(VAL_W), .DEPTH(HIST_LEN)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ws_r), .wdata(in_chan.u_in),
    .raddr(raddr), .rdata(u_rd)
  );
  rds_ram #(.WIDTH(VAL_W), .DEPTH(HIST_LEN)) v_ram (
    .clk(clk), .we(ram_we), .waddr(ws_r), .wdata(in_chan.v_in),
    .raddr(raddr), .rdata(v_rd)
  );

  // counters and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ws_r      <= '0;
      pend_r    <= '0;
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      c_r       <= '0;
      border_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (acc_in) begin
        c_r <= centre_slot;
        border_r <= (out_row_r == '0) || (out_row_r == ROW_W'(GRID_ROWS - 1)) ||
                    (out_col_r == '0) || (out_col_r == COL_W'(GRID_COLS - 1));
      end
      if (acc_in && is_cell) begin
        ws_r <= slot_wrap(SW1'(ws_r) + SW1'(1));
        if (in_col_r == COL_W'(GRID_COLS - 1)) begin
          in_col_r <= '0;
          in_row_r <= (in_row_r == ROW_W'(GRID_ROWS - 1)) ? '0 : in_row_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
      end
      // pending: one more per stored cell, one less per emitted result
      case ({acc_in & is_cell, out_load})
        2'b10:   pend_r <= pend_r + 1'b1;
        2'b01:   pend_r <= pend_r - 1'b1;
        default: ;
      endcase
      if (out_load) begin
        if (out_col_r == COL_W'(GRID_COLS - 1)) begin
          out_col_r <= '0;
          out_row_r <= (out_row_r == ROW_W'(GRID_ROWS - 1)) ? '0 : out_row_r + 1'b1;
        end else begin
          out_col_r <= out_col_r + 1'b1;
        end
      end
    end
  end

  // datapath registers
  val_t               a_r, b_r;
  logic signed [20:0] su_r, sv_r;
  logic signed [21:0] lu_r, lv_r;
  logic signed [35:0] bb_r;
  logic signed [36:0] fu_r;
  logic signed [35:0] kv_r;
  logic signed [38:0] dfu_r, dfv_r;
  logic signed [53:0] abb_r;
  logic signed [41:0] d_u_r, d_v_r;
  logic signed [59:0] p_u_r, p_v_r;

  logic signed [20:0] su_add, sv_add;
  logic signed [54:0] ab_lo_u, ab_lo_v;
  logic signed [41:0] d_u_nxt, d_v_nxt;
  logic signed [59:0] rp_u, rp_v;
  logic signed [28:0] nu_w, nv_w;
  val_t               nu, nv;

  assign su_add = su_r + 21'(signed'(u_rd));
  assign sv_add = sv_r + 21'(signed'(v_rd));

  // derivative rounding of the cubic term to Q.32: floor((half -+ uvv)/2^16)
  assign ab_lo_u = 55'sd32768 - 55'(abb_r);
  assign ab_lo_v = 55'sd32768 + 55'(abb_r);
  assign d_u_nxt = 42'(dfu_r) + 42'(fu_r) + 42'(ab_lo_u >>> 16);
  assign d_v_nxt = 42'(dfv_r) - 42'(kv_r) + 42'(ab_lo_v >>> 16);

  // Euler step, round to Q.16, saturate
  assign rp_u = (p_u_r + 60'sd2147483648) >>> 32;
  assign rp_v = (p_v_r + 60'sd2147483648) >>> 32;
  assign nu_w = 29'(rp_u) + 29'(a_r);
  assign nv_w = 29'(rp_v) + 29'(b_r);

  always_comb begin
    if (border_r) begin
      nu = a_r;
      nv = b_r;
    end else begin
      if (nu_w > 29'sd131071)       nu = val_t'(VAL_MAX);
      else if (nu_w < -29'sd131072) nu = val_t'(VAL_MIN);
      else                          nu = nu_w[VAL_W-1:0];
      if (nv_w > 29'sd131071)       nv = val_t'(VAL_MAX);
      else if (nv_w < -29'sd131072) nv = val_t'(VAL_MIN);
      else                          nv = nv_w[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_RD_U: begin
        a_r <= u_rd;
        b_r <= v_rd;
      end
      S_RD_D: begin
        su_r <= 21'(signed'(u_rd));
        sv_r <= 21'(signed'(v_rd));
      end
      S_RD_L, S_RD_R, S_ACC: begin
        su_r <= su_add;
        sv_r <= sv_add;
      end
      S_MUL1: begin
        lu_r <= 22'(su_r) - (22'(a_r) <<< 2);
        lv_r <= 22'(sv_r) - (22'(b_r) <<< 2);
        bb_r <= 36'(b_r) * 36'(b_r);
        fu_r <= 37'(signed'({1'b0, feed_r})) * (37'sd65536 - 37'(a_r));
        kv_r <= 36'(signed'({2'b00, feed_r} + {2'b00, kill_r})) * 36'(b_r);
      end
      S_MUL2: begin
        dfu_r <= 39'(signed'({1'b0, du_r})) * 39'(lu_r);
        dfv_r <= 39'(signed'({1'b0, dv_r})) * 39'(lv_r);
        abb_r <= 54'(a_r) * 54'(bb_r);
      end
      S_SUM: begin
        d_u_r <= d_u_nxt;
        d_v_r <= d_v_nxt;
      end
      S_MUL3: begin
        p_u_r <= 60'(signed'({1'b0, dt_r})) * 60'(d_u_r);
        p_v_r <= 60'(signed'({1'b0, dt_r})) * 60'(d_v_r);
      end
      default: ;
    endcase
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan.u_out           <= nu;
      out_chan.v_out           <= nv;
      out_chan.above_threshold <= (nv > thr_r);
      out_chan.frame_last      <= (out_row_r == ROW_W'(GRID_ROWS - 1)) &&
                                  (out_col_r == COL_W'(GRID_COLS - 1));
    end
  end

  assign out_chan.valid = out_valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rds_checker.sv =====
// ----------------------------------------------------------------------------
// rds_checker
// Port-level checks on the stencil step unit, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rds_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [17:0] u_out,
  input wire logic [17:0] v_out,
  input wire logic        pready
);

  // no result word straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a result waiting is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a waiting result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(u_out) && $stable(v_out))
    else $error("result changed while stalled");

  // the configuration port never stalls the bus
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind reaction_diffusion_stencil_step_unit rds_checker u_rds_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_chan.valid),
  .in_ready(in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .u_out(out_chan.u_out),
  .v_out(out_chan.v_out),
  .pready(pready)
);

`default_nettype wire

// ===== verif/reaction_diffusion_stencil_step_unit_tb.sv =====
// ----------------------------------------------------------------------------
// reaction_diffusion_stencil_step_unit_tb
// Streams the first rows of a frame through the Gray-Scott stencil unit, with
// several coefficient sets and random back-pressure on both channels. Every
// result word is checked against a predictor kept inside this bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module reaction_diffusion_stencil_step_unit_tb;
  import rds_pkg::*;

  typedef struct packed {
    val_t u;
    val_t v;
    logic above;
    logic last;
  } cell_res_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  rds_in_if  in_chan ();
  rds_out_if out_chan ();

  reaction_diffusion_stencil_step_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock: 8 ns period
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  longint          coef_du, coef_dv, coef_f, coef_k, coef_dt;
  longint          thresh;
  longint          hist_u [HIST_LEN];
  longint          hist_v [HIST_LEN];
  int              wr_slot, in_row, in_col, pend, out_row, out_col;
  cell_res_t       expected_cells [$];
  int              errors = 0;
  int              words_sent = 0;
  int              results_seen = 0;
  bit              no_idle = 1'b0;

  function automatic longint floor_sh(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint round_sh(longint x, int n);
    return floor_sh(x + (longint'(1) << (n - 1)), n);
  endfunction

  function automatic longint clamp18(longint x);
    if (x > VAL_MAX) return VAL_MAX;
    if (x < VAL_MIN) return VAL_MIN;
    return x;
  endfunction

  function automatic longint euler_step(longint old, longint d48);
    longint d32, acc;
    d32 = round_sh(d48, 16);
    acc = coef_dt * d32 + (old <<< 32);
    return clamp18(round_sh(acc, 32));
  endfunction

  // emit the oldest pending cell into the expectation queue
  task automatic emit_oldest_cell();
    int s, up, dn, lf, rt;
    longint a, b, nu, nv, lu, lv, uvv, du, dv;
    cell_res_t r;
    s = (wr_slot + HIST_LEN - pend) % HIST_LEN;
    a = hist_u[s];
    b = hist_v[s];
    nu = a;
    nv = b;
    if (out_row >= 1 && out_row + 1 < GRID_ROWS && out_col >= 1 && out_col + 1 < GRID_COLS) begin
      up = (s + HIST_LEN - GRID_COLS) % HIST_LEN;
      dn = (s + GRID_COLS) % HIST_LEN;
      lf = (s + HIST_LEN - 1) % HIST_LEN;
      rt = (s + 1) % HIST_LEN;
      lu = hist_u[up] + hist_u[dn] + hist_u[lf] + hist_u[rt] - 4 * a;
      lv = hist_v[up] + hist_v[dn] + hist_v[lf] + hist_v[rt] - 4 * b;
      uvv = a * b * b;
      du = coef_du * lu * 65536 - uvv + coef_f * (65536 - a) * 65536;
      dv = coef_dv * lv * 65536 + uvv - (coef_f + coef_k) * b * 65536;
      nu = euler_step(a, du);
      nv = euler_step(b, dv);
    end
    r.u = val_t'(nu);
    r.v = val_t'(nv);
    r.above = (nv > thresh);
    r.last = (out_row == GRID_ROWS - 1 && out_col == GRID_COLS - 1);
    expected_cells.push_back(r);
    pend--;
    out_col++;
    if (out_col >= GRID_COLS) begin
      out_col = 0;
      out_row++;
      if (out_row >= GRID_ROWS) out_row = 0;
    end
  endtask

  task automatic predict_word(logic drn, val_t u, val_t v);
    if (drn) begin
      if (in_row == 0 && in_col == 0 && pend > 0) emit_oldest_cell();
      return;
    end
    hist_u[wr_slot] = longint'(u);
    hist_v[wr_slot] = longint'(v);
    wr_slot = (wr_slot + 1) % HIST_LEN;
    pend++;
    in_col++;
    if (in_col >= GRID_COLS) begin
      in_col = 0;
      in_row++;
      if (in_row >= GRID_ROWS) in_row = 0;
    end
    if (pend > GRID_COLS + 1) emit_oldest_cell();
  endtask

  // send one word; prediction runs at acceptance, valid stays up for the next
  task automatic send_word(logic drn, val_t u, val_t v);
    while (!no_idle && $urandom_range(99) < 19) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.drain <= drn;
    in_chan.u_in  <= u;
    in_chan.v_in  <= v;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_word(drn, u, v);
    words_sent++;
  endtask

  task automatic send_cell(val_t u, val_t v);
    send_word(1'b0, u, v);
  endtask

  // a short run of drain words away from the frame boundary
  task automatic send_drains(int n);
    for (int i = 0; i < n; i++) send_word(1'b1, val_t'($urandom), val_t'($urandom));
  endtask

  // stop sending and wait until every expected result has come
  task automatic wait_quiet();
    in_chan.valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [CFG_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DIFF_U:    coef_du = longint'(val[15:0]);
      REG_DIFF_V:    coef_dv = longint'(val[15:0]);
      REG_FEED:      coef_f  = longint'(val[15:0]);
      REG_KILL:      coef_k  = longint'(val[15:0]);
      REG_TIME_STEP: coef_dt = longint'(val[15:0]);
      REG_V_THRESH:  thresh  = longint'(val_t'(val[VAL_W-1:0]));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_all(logic [15:0] du, logic [15:0] dv, logic [15:0] f,
                         logic [15:0] k, logic [15:0] dt, logic [17:0] th);
    cfg_write(REG_DIFF_U, CFG_DW'(du));
    cfg_write(REG_DIFF_V, CFG_DW'(dv));
    cfg_write(REG_FEED, CFG_DW'(f));
    cfg_write(REG_KILL, CFG_DW'(k));
    cfg_write(REG_TIME_STEP, CFG_DW'(dt));
    cfg_write(REG_V_THRESH, {14'd0, th});
  endtask

  function automatic val_t pick_val(int mode);
    case (mode)
      0: return val_t'(VAL_MAX);
      1: return val_t'(VAL_MIN);
      2: return val_t'(0);
      3: return val_t'($urandom_range(70000, 0));
      default: return val_t'($urandom);
    endcase
  endfunction

  // directed: a drain with nothing pending, extremes of fields and a mid-frame drain
  task automatic test_directed();
    send_word(1'b1, '0, '0);                        // drain with nothing pending
    send_cell(val_t'(VAL_MAX), val_t'(VAL_MIN));
    send_cell(val_t'(VAL_MIN), val_t'(VAL_MAX));
    send_cell('0, '0);
    send_word(1'b1, val_t'(VAL_MAX), val_t'(VAL_MAX)); // drain mid-frame
    for (int i = 0; i < 8; i++) send_cell(pick_val(i % 5), pick_val((i + 2) % 5));
  endtask

  // a run of cells with random content of a chosen flavour, with drain words mixed in
  task automatic test_stream(int flavour, int n_cells, bit steady);
    val_t u, v;
    no_idle = steady;
    for (int i = 0; i < n_cells; i++) begin
      if (flavour == 0) begin
        u = val_t'($urandom_range(65536, 0));
        v = val_t'($urandom_range(20000, 0));
      end else begin
        u = pick_val($urandom_range(4));
        v = pick_val($urandom_range(4));
      end
      if ($urandom_range(99) < 3) send_word(1'b1, val_t'($urandom), val_t'($urandom));
      send_cell(u, v);
    end
    send_drains(4);
    no_idle = 1'b0;
  endtask

  // results: random stall, check each against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        results_seen <= results_seen + 1;
        if (expected_cells.size() == 0) begin
          errors++;
          $display("%0t: unexpected result u=%0d v=%0d", $time, out_chan.u_out, out_chan.v_out);
        end else begin
          cell_res_t e;
          e = expected_cells.pop_front();
          if (out_chan.u_out !== e.u || out_chan.v_out !== e.v ||
              out_chan.above_threshold !== e.above || out_chan.frame_last !== e.last) begin
            errors++;
            $display("%0t: exp u=%0d v=%0d above=%0b last=%0b got u=%0d v=%0d above=%0b last=%0b",
                     $time, e.u, e.v, e.above, e.last, out_chan.u_out, out_chan.v_out,
                     out_chan.above_threshold, out_chan.frame_last);
          end
        end
      end
      out_chan.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 19);
    end
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.drain = 1'b0;
    in_chan.u_in  = '0;
    in_chan.v_in  = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    coef_du = longint'(DIFF_U_RST); coef_dv = longint'(DIFF_V_RST);
    coef_f = longint'(FEED_RST); coef_k = longint'(KILL_RST);
    coef_dt = longint'(TIME_STEP_RST); thresh = longint'(val_t'(V_THRESH_RST));
    foreach (hist_u[i]) begin
      hist_u[i] = 0;
      hist_v[i] = 0;
    end
    wr_slot = 0; in_row = 0; in_col = 0; pend = 0; out_row = 0; out_col = 0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients first, then extremes and random settings
    test_directed();
    test_stream(0, 400, 1'b0);
    wait_quiet();
    cfg_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 18'h1FFFF);
    test_stream(1, 220, 1'b0);
    wait_quiet();
    cfg_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 18'h20000);
    test_stream(1, 220, 1'b0);
    wait_quiet();
    cfg_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            18'($urandom));
    test_stream(0, 260, 1'b1);
    wait_quiet();

    $display("Covered %0d input words and %0d results over the first rows of a frame,",
             words_sent, results_seen);
    $display("with default, all-ones, all-zero and random coefficient sets.");
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
